FILE: hdl/qss_pkg.sv
package qss_pkg;

  // Capacities
  localparam int PATTERN_MAX   = 64;
  localparam int TEXT_MAX      = 4096;
  localparam int SHIFT_ENTRIES = 32;

  // Derived widths
  localparam int PLEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int TLEN_W  = $clog2(TEXT_MAX + 1);
  localparam int PADDR_W = $clog2(PATTERN_MAX);
  localparam int TADDR_W = $clog2(TEXT_MAX);
  localparam int TIDX_W  = $clog2(SHIFT_ENTRIES);
  localparam int SHIFT_W = $clog2(PATTERN_MAX + 2);
  localparam int SUM_W   = TLEN_W + 1;

  // Command codes
  localparam logic [1:0] CMD_PATTERN = 2'd0;
  localparam logic [1:0] CMD_TEXT    = 2'd1;
  localparam logic [1:0] CMD_SEARCH  = 2'd2;

  // Request and result payloads
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [11:0] position;
    logic        overflow;
  } rsp_t;

  // Store status seen by the sequencer
  typedef struct packed {
    logic [PLEN_W-1:0] plen;
    logic [TLEN_W-1:0] tlen;
    logic              dropped;
  } store_stat_t;

  // Read addresses into the stores
  typedef struct packed {
    logic [TADDR_W-1:0] text_addr;
    logic [PADDR_W-1:0] pat_addr;
  } rd_addr_t;

  // Shift table write port
  typedef struct packed {
    logic              en;
    logic [TIDX_W-1:0] idx;
    logic [SHIFT_W-1:0] val;
  } tbl_wr_t;

endpackage

FILE: hdl/qss_store.sv
module qss_store (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_en,
  input  qss_pkg::req_t       req,
  input  logic                clear,
  input  qss_pkg::rd_addr_t   rd,
  output qss_pkg::store_stat_t stat,
  output logic [7:0]          text_q,
  output logic [7:0]          pat_q
);
  import qss_pkg::*;

  logic [7:0] pat_mem  [PATTERN_MAX];
  logic [7:0] text_mem [TEXT_MAX];

  logic [PLEN_W-1:0] plen;
  logic [TLEN_W-1:0] tlen;
  logic              dropped;

  logic nonzero;
  logic pat_load;
  logic text_load;
  logic pat_full;
  logic text_full;

  // Load decode; zero bytes are terminators and are dropped silently
  assign nonzero   = (req.data_byte != 8'd0);
  assign pat_load  = load_en && nonzero && (req.command == CMD_PATTERN);
  assign text_load = load_en && nonzero && (req.command == CMD_TEXT);
  assign pat_full  = (plen == PLEN_W'(PATTERN_MAX));
  assign text_full = (tlen == TLEN_W'(TEXT_MAX));

  // Pattern memory, registered read
  always_ff @(posedge clk) begin
    if (pat_load && !pat_full) begin
      pat_mem[plen[PADDR_W-1:0]] <= req.data_byte;
    end
    pat_q <= pat_mem[rd.pat_addr];
  end

  // Text memory, registered read
  always_ff @(posedge clk) begin
    if (text_load && !text_full) begin
      text_mem[tlen[TADDR_W-1:0]] <= req.data_byte;
    end
    text_q <= text_mem[rd.text_addr];
  end

  // Fill counts and overflow flag; a search clears them
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      plen    <= '0;
      tlen    <= '0;
      dropped <= 1'b0;
    end else begin
      if (pat_load) begin
        if (pat_full) dropped <= 1'b1;
        else          plen    <= plen + PLEN_W'(1);
      end
      if (text_load) begin
        if (text_full) dropped <= 1'b1;
        else           tlen    <= tlen + TLEN_W'(1);
      end
    end
  end

  assign stat.plen    = plen;
  assign stat.tlen    = tlen;
  assign stat.dropped = dropped;

  a_plen_bound: assert property (@(posedge clk) disable iff (rst)
    plen <= PLEN_W'(PATTERN_MAX))
    else $error("pattern fill count past capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    clear |=> (plen == '0) && (tlen == '0) && !dropped)
    else $error("stores not emptied after search");

endmodule

FILE: hdl/qss_shift_table.sv
module qss_shift_table (
  input  logic                      clk,
  input  qss_pkg::tbl_wr_t          wr,
  input  logic [qss_pkg::TIDX_W-1:0] rd_idx,
  output logic [qss_pkg::SHIFT_W-1:0] rd_val
);
  import qss_pkg::*;

  logic [SHIFT_W-1:0] entry [SHIFT_ENTRIES];

  // One write per cycle from the sequencer
  always_ff @(posedge clk) begin
    if (wr.en) begin
      entry[wr.idx] <= wr.val;
    end
  end

  // Lookup by low bits of the text byte
  assign rd_val = entry[rd_idx];

endmodule

FILE: hdl/qss_seq.sv
module qss_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  qss_pkg::store_stat_t stat,
  input  logic [7:0]           text_q,
  input  logic [7:0]           pat_q,
  input  logic [qss_pkg::SHIFT_W-1:0] shift_val,
  output qss_pkg::rd_addr_t    rd,
  output qss_pkg::tbl_wr_t     tbl_wr,
  output logic [qss_pkg::TIDX_W-1:0] shift_idx,
  output logic                 busy,
  output logic                 clear,
  output logic                 done,
  output qss_pkg::rsp_t        rsp
);
  import qss_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_FILL      = 4'd1;
  localparam logic [3:0] S_BUILD_RD  = 4'd2;
  localparam logic [3:0] S_BUILD_WR  = 4'd3;
  localparam logic [3:0] S_MATCH_RD  = 4'd4;
  localparam logic [3:0] S_MATCH_CMP = 4'd5;
  localparam logic [3:0] S_SHIFT_RD  = 4'd6;
  localparam logic [3:0] S_SHIFT_ADD = 4'd7;
  localparam logic [3:0] S_SHIFT_CHK = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  logic [3:0]        state, state_next;
  logic [TLEN_W-1:0] p, p_next;
  logic [PLEN_W-1:0] k, k_next;
  logic              found, found_next;
  logic [11:0]       pos, pos_next;

  logic [PLEN_W-1:0] m;
  logic [TLEN_W-1:0] n;
  logic              k_last;

  // Shared adder
  logic [SUM_W-1:0] alu_a, alu_b, alu_sum;

  assign m       = stat.plen;
  assign n       = stat.tlen;
  assign k_last  = (k == PLEN_W'(m - PLEN_W'(1)));
  assign alu_sum = alu_a + alu_b;

  // Adder operand select per step
  always_comb begin
    alu_a = SUM_W'(p);
    alu_b = SUM_W'(m);
    case (state)
      S_FILL: begin
        alu_a = SUM_W'(m);
        alu_b = SUM_W'(1);
      end
      S_MATCH_RD:  alu_b = SUM_W'(k);
      S_SHIFT_ADD: alu_b = SUM_W'(shift_val);
      default: ;
    endcase
  end

  // Store and table access
  always_comb begin
    rd.text_addr = alu_sum[TADDR_W-1:0];
    rd.pat_addr  = k[PADDR_W-1:0];
    shift_idx    = text_q[TIDX_W-1:0];
    tbl_wr.en    = 1'b0;
    tbl_wr.idx   = k[TIDX_W-1:0];
    tbl_wr.val   = alu_sum[SHIFT_W-1:0];
    case (state)
      S_FILL: tbl_wr.en = 1'b1;
      S_BUILD_WR: begin
        tbl_wr.en  = 1'b1;
        tbl_wr.idx = pat_q[TIDX_W-1:0];
        tbl_wr.val = SHIFT_W'(m - k);
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_next = state;
    p_next     = p;
    k_next     = k;
    found_next = found;
    pos_next   = pos;
    case (state)
      S_IDLE: begin
        if (go) begin
          found_next = 1'b0;
          pos_next   = '0;
          k_next     = '0;
          p_next     = '0;
          if (m == '0) begin
            found_next = (n == '0);
            state_next = S_DONE;
          end else if (TLEN_W'(m) > n) begin
            state_next = S_DONE;
          end else begin
            state_next = S_FILL;
          end
        end
      end
      S_FILL: begin
        if (k[TIDX_W-1:0] == TIDX_W'(SHIFT_ENTRIES - 1)) begin
          k_next     = '0;
          state_next = S_BUILD_RD;
        end else begin
          k_next = k + PLEN_W'(1);
        end
      end
      S_BUILD_RD: state_next = S_BUILD_WR;
      S_BUILD_WR: begin
        if (k_last) begin
          k_next     = '0;
          state_next = S_MATCH_RD;
        end else begin
          k_next     = k + PLEN_W'(1);
          state_next = S_BUILD_RD;
        end
      end
      S_MATCH_RD: state_next = S_MATCH_CMP;
      S_MATCH_CMP: begin
        if (text_q == pat_q) begin
          if (k_last) begin
            found_next = 1'b1;
            pos_next   = p[11:0];
            state_next = S_DONE;
          end else begin
            k_next     = k + PLEN_W'(1);
            state_next = S_MATCH_RD;
          end
        end else if (alu_sum >= SUM_W'(n)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD:  state_next = S_SHIFT_ADD;
      S_SHIFT_ADD: begin
        p_next     = alu_sum[TLEN_W-1:0];
        state_next = S_SHIFT_CHK;
      end
      S_SHIFT_CHK: begin
        // window past text end ends the search
        if (alu_sum > SUM_W'(n)) begin
          state_next = S_DONE;
        end else begin
          k_next     = '0;
          state_next = S_MATCH_RD;
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      found <= 1'b0;
      pos   <= '0;
    end else begin
      state <= state_next;
      found <= found_next;
      pos   <= pos_next;
    end
    p <= p_next;
    k <= k_next;
  end

  // Result and clear
  assign busy         = (state != S_IDLE);
  assign done         = (state == S_DONE);
  assign clear        = done;
  assign rsp.found    = found;
  assign rsp.position = pos;
  assign rsp.overflow = stat.dropped;

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe longer than one cycle");

  a_tbl_write_phase: assert property (@(posedge clk) disable iff (rst)
    tbl_wr.en |-> (state == S_FILL) || (state == S_BUILD_WR))
    else $error("shift table written outside build");

  a_window_in_text: assert property (@(posedge clk) disable iff (rst)
    (state == S_MATCH_RD) |-> (SUM_W'(p) + SUM_W'(m) <= SUM_W'(n)))
    else $error("compare window beyond text end");

  a_found_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (pos == '0))
    else $error("position nonzero on miss");

endmodule

FILE: hdl/quick_search_substring_find_unit.sv
// Channel   Ports                        Handshake
// request   start, busy, request         taken when start && !busy
// result    done, result                 one-cycle strobe, no back-pressure
//
// Pattern and text loads are stored directly; busy stays low after them.
// A search with an empty or too-long pattern goes straight to the result
// strobe in the cycle after the request. Otherwise it builds the shift
// table (sweep of the table, then one pattern memory read per byte),
// then compares byte by byte and shifts the window, with text addresses,
// shifts and window checks on one shared adder; then the result strobe.
// Reset is synchronous and empties pattern, text and overflow flag; the
// stores themselves hold unwritten data. The receiver cannot stall results.
module quick_search_substring_find_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  qss_pkg::req_t request,
  output logic          done,
  output qss_pkg::rsp_t result
);
  import qss_pkg::*;

  logic        accept;
  logic        go;
  logic        clear;
  store_stat_t stat;
  rd_addr_t    rd;
  tbl_wr_t     tbl_wr;
  logic [7:0]  text_q;
  logic [7:0]  pat_q;
  logic [TIDX_W-1:0]  shift_idx;
  logic [SHIFT_W-1:0] shift_val;

  // Request decode
  assign accept = start && !busy;
  assign go     = accept && (request.command == CMD_SEARCH);

  qss_store u_store (
    .clk     (clk),
    .rst     (rst),
    .load_en (accept),
    .req     (request),
    .clear   (clear),
    .rd      (rd),
    .stat    (stat),
    .text_q  (text_q),
    .pat_q   (pat_q)
  );

  qss_shift_table u_table (
    .clk    (clk),
    .wr     (tbl_wr),
    .rd_idx (shift_idx),
    .rd_val (shift_val)
  );

  qss_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .stat      (stat),
    .text_q    (text_q),
    .pat_q     (pat_q),
    .shift_val (shift_val),
    .rd        (rd),
    .tbl_wr    (tbl_wr),
    .shift_idx (shift_idx),
    .busy      (busy),
    .clear     (clear),
    .done      (done),
    .rsp       (result)
  );

endmodule

FILE: bench/quick_search_substring_find_unit_tb.sv
module quick_search_substring_find_unit_tb;
  import qss_pkg::*;

  // Command code with no meaning; the block must ignore it
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [7:0] NUL_BYTE   = 8'h00;
  localparam int RANDOM_ITEMS = 1900;
  localparam int REPORT_LIMIT = 10;

  // Tracks loaded pattern/text, predicts each search outcome, checks results
  class search_ledger;
    logic [7:0] pat_mem [PATTERN_MAX];
    logic [7:0] txt_mem [TEXT_MAX];
    int pat_len = 0;
    int txt_len = 0;
    bit lost_bytes = 1'b0;
    rsp_t due_outcomes [$];
    int errors = 0;

    function void note_error(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("ERROR: %s", msg);
    endfunction

    // Sunday quick search over the stores loaded since the last search
    function rsp_t quick_search();
      rsp_t r;
      int skip [SHIFT_ENTRIES];
      int p;
      bit hit;
      r = '0;
      r.overflow = lost_bytes;
      if (pat_len == 0) begin
        r.found = (txt_len == 0);
        return r;
      end
      if (pat_len > txt_len) return r;
      foreach (skip[i]) skip[i] = pat_len + 1;
      for (int k = 0; k < pat_len; k++) skip[pat_mem[k][4:0]] = pat_len - k;
      p = 0;
      while (1) begin
        hit = 1'b1;
        for (int k = 0; k < pat_len; k++)
          if (txt_mem[p + k] != pat_mem[k]) hit = 1'b0;
        if (hit) begin
          r.found = 1'b1;
          r.position = 12'(p);
          return r;
        end
        if (p + pat_len >= txt_len) return r;
        p += skip[txt_mem[p + pat_len][4:0]];
        if (p + pat_len > txt_len) return r;
      end
      return r;
    endfunction

    function void note_request(req_t r);
      case (r.command)
        CMD_PATTERN: begin
          if (r.data_byte != NUL_BYTE) begin
            if (pat_len < PATTERN_MAX) begin
              pat_mem[pat_len] = r.data_byte;
              pat_len++;
            end else begin
              lost_bytes = 1'b1;
            end
          end
        end
        CMD_TEXT: begin
          if (r.data_byte != NUL_BYTE) begin
            if (txt_len < TEXT_MAX) begin
              txt_mem[txt_len] = r.data_byte;
              txt_len++;
            end else begin
              lost_bytes = 1'b1;
            end
          end
        end
        CMD_SEARCH: begin
          due_outcomes.push_back(quick_search());
          pat_len = 0;
          txt_len = 0;
          lost_bytes = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (due_outcomes.size() == 0) begin
        note_error($sformatf("unexpected result found=%0b position=%0d overflow=%0b",
                             got.found, got.position, got.overflow));
        return;
      end
      want = due_outcomes.pop_front();
      if (got.found !== want.found)
        note_error($sformatf("found: expected %0b, got %0b", want.found, got.found));
      if (got.position !== want.position)
        note_error($sformatf("position: expected %0d, got %0d",
                             want.position, got.position));
      if (got.overflow !== want.overflow)
        note_error($sformatf("overflow: expected %0b, got %0b",
                             want.overflow, got.overflow));
    endfunction

    function int outstanding();
      return due_outcomes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t result;

  search_ledger ledger;
  int burst_left = 0;
  int meaningful_items = 0;

  quick_search_substring_find_unit dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Results cannot be held off; check every strobe
  always @(posedge clk) begin
    if (!rst && done) ledger.check_result(result);
  end

  // Bursts of back-to-back requests with random gaps between them
  task automatic drive_request(input logic [1:0] cmd, input logic [7:0] b);
    req_t r;
    int gap;
    r.command = cmd;
    r.data_byte = b;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    ledger.note_request(r);
  endtask

  // Stop sending until every pending search has answered
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (ledger.outstanding() != 0);
  endtask

  // Interleave pattern and text loads, optional ignored noise, then search
  task automatic run_sequence(input logic [7:0] pat [$], input logic [7:0] txt [$],
                              input bit noisy);
    while (pat.size() + txt.size() > 0) begin
      if (noisy && $urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 1)
          drive_request(CMD_UNUSED, 8'($urandom));
        else
          drive_request($urandom_range(0, 1) ? CMD_TEXT : CMD_PATTERN, NUL_BYTE);
      end else if (txt.size() == 0 || (pat.size() != 0 && $urandom_range(0, 1) == 0)) begin
        drive_request(CMD_PATTERN, pat.pop_front());
        meaningful_items++;
      end else begin
        drive_request(CMD_TEXT, txt.pop_front());
        meaningful_items++;
      end
    end
    drive_request(CMD_SEARCH, 8'($urandom));
    meaningful_items++;
  endtask

  // Small alphabets so that matches and partial matches are common
  task automatic random_case();
    int m;
    int n;
    int alpha_n;
    int at;
    logic [7:0] alpha [4];
    logic [7:0] pat [$];
    logic [7:0] txt [$];
    if ($urandom_range(0, 15) == 0) begin
      m = $urandom_range(40, 70);
      n = $urandom_range(0, 220);
    end else begin
      m = $urandom_range(0, 6);
      n = $urandom_range(0, 40);
    end
    alpha_n = $urandom_range(1, 4);
    foreach (alpha[i]) alpha[i] = 8'($urandom_range(1, 255));
    // same shift-table slot, usually a different byte
    if ($urandom_range(0, 3) == 0)
      alpha[1] = {3'($urandom_range(1, 7)), alpha[0][4:0]};
    repeat (n) txt.push_back(alpha[$urandom_range(0, alpha_n - 1)]);
    if (m > 0 && n >= m && $urandom_range(0, 2) != 0) begin
      at = $urandom_range(0, n - m);
      for (int k = 0; k < m; k++) pat.push_back(txt[at + k]);
      if ($urandom_range(0, 2) == 0)
        pat[$urandom_range(0, m - 1)] = alpha[$urandom_range(0, alpha_n - 1)];
    end else begin
      repeat (m) pat.push_back(alpha[$urandom_range(0, alpha_n - 1)]);
    end
    run_sequence(pat, txt, 1'b1);
  endtask

  initial begin
    ledger = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty pattern, empty text
    drive_request(CMD_SEARCH, 8'hFF);
    // zero bytes and the unused command change nothing
    drive_request(CMD_PATTERN, NUL_BYTE);
    drive_request(CMD_TEXT, NUL_BYTE);
    drive_request(CMD_UNUSED, 8'hFF);
    drive_request(CMD_SEARCH, NUL_BYTE);
    // empty pattern, non-empty text
    drive_request(CMD_TEXT, "b");
    drive_request(CMD_SEARCH, 8'h00);
    // pattern longer than text
    drive_request(CMD_PATTERN, "a");
    drive_request(CMD_PATTERN, "b");
    drive_request(CMD_TEXT, "a");
    drive_request(CMD_SEARCH, 8'h55);
    // byte extremes, match at offset 1
    drive_request(CMD_PATTERN, 8'hFF);
    drive_request(CMD_PATTERN, 8'h01);
    drive_request(CMD_TEXT, 8'h01);
    drive_request(CMD_TEXT, 8'hFF);
    drive_request(CMD_TEXT, 8'h01);
    drive_request(CMD_SEARCH, 8'hAA);
    // shifted window runs past the end of the text
    drive_request(CMD_PATTERN, "a");
    drive_request(CMD_PATTERN, "b");
    drive_request(CMD_PATTERN, "c");
    drive_request(CMD_TEXT, "a");
    drive_request(CMD_TEXT, "b");
    drive_request(CMD_TEXT, "x");
    drive_request(CMD_TEXT, "a");
    drive_request(CMD_TEXT, "b");
    drive_request(CMD_SEARCH, 8'h00);
    hold_until_drained();

    while (meaningful_items < RANDOM_ITEMS) begin
      random_case();
      if ($urandom_range(0, 7) == 0) hold_until_drained();
    end

    start <= 1'b0;
    do @(posedge clk); while (ledger.outstanding() != 0);
    repeat (40) @(posedge clk);
    if (ledger.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Hang guard, several times the slowest legal run
  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
